// ===== rtl/flr_pkg.sv =====
// ----------------------------------------------------------------------------
// flr_pkg: shared types and constants of the line rasterizer
// Payload structs, controller state, control/status bundles and the
// configuration register indexes.
// ----------------------------------------------------------------------------
package flr_pkg;

	localparam int COORD_MAX = 31;
	localparam int COORD_W   = $clog2(COORD_MAX + 1);
	localparam int TWICE_W   = COORD_W + 2;
	localparam int ERR_W     = COORD_W + 3;
	// non-final cells allowed per line; the final cell comes on top
	localparam int MAX_STEPS = 2 * COORD_MAX;
	localparam int CNT_W     = $clog2(MAX_STEPS + 2);

	localparam int CFG_IDX_W = 1;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_WIDTH  = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_GRID_HEIGHT = 1'b1;

	typedef struct packed {
		logic [COORD_W-1:0] start_x;
		logic [COORD_W-1:0] start_y;
		logic [COORD_W-1:0] end_x;
		logic [COORD_W-1:0] end_y;
	} line_req_t;

	typedef struct packed {
		logic [COORD_W-1:0] cell_column;
		logic [COORD_W-1:0] cell_row;
		logic               drawn;
		logic               last_cell;
	} cell_t;

	typedef enum logic {
		ST_IDLE,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic load;   // latch a new line request
		logic step;   // emit current cell and advance
	} dp_cmd_t;

	typedef struct packed {
		logic out_free;  // output register can take a cell this cycle
		logic last;      // current cell is the final one of the line
	} dp_status_t;

endpackage

// ===== rtl/four_connected_line_rasterizer.sv =====
// ----------------------------------------------------------------------------
// four_connected_line_rasterizer: 4-connected Bresenham line rasterizer
// Top level: configuration registers, controller and datapath.
// ----------------------------------------------------------------------------
// Usage:
//  - in channel: one line request (two endpoints) per transfer. A transfer
//    happens when in_valid is high and in_stall is low. in_stall is low
//    only while no line is being walked.
//  - out channel: one cell per transfer, from the start point to the end
//    point; the end point carries last_cell. Coincident endpoints give a
//    single undrawn cell with last_cell set.
//  - Flow: a request transfer latches the line and starts the run state;
//    each stepped cell passes through the output register to out_valid.
//    The Bresenham stepper advances and emits one cell per cycle whenever
//    the output register can take it; a line has at most 63 cells.
//  - Receiver stall: the output register holds its cell and the stepper
//    waits; nothing is dropped.
//  - cfg_we/cfg_index/cfg_data write grid_width (index 0) and
//    grid_height (index 1); write only while idle.
//  - Reset: both grid sizes return to 30 and the block goes idle.
// ----------------------------------------------------------------------------
module four_connected_line_rasterizer (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  flr_pkg::line_req_t            in_data,
	output logic                          out_valid,
	input  logic                          out_stall,
	output flr_pkg::cell_t                out_data,
	input  logic                          cfg_we,
	input  logic [flr_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [flr_pkg::COORD_W-1:0]   cfg_data
);

	logic [flr_pkg::COORD_W-1:0] grid_width_q, grid_height_q;
	flr_pkg::dp_cmd_t            cmd;
	flr_pkg::dp_status_t         sts;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			grid_width_q  <= flr_pkg::COORD_W'(30);
			grid_height_q <= flr_pkg::COORD_W'(30);
		end else if (cfg_we) begin
			case (cfg_index)
				flr_pkg::CFG_GRID_WIDTH:  grid_width_q  <= cfg_data;
				flr_pkg::CFG_GRID_HEIGHT: grid_height_q <= cfg_data;
				default: ;
			endcase
		end
	end

	flr_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	flr_dpath u_dpath (
		.clk         (clk),
		.arst_n      (arst_n),
		.cmd         (cmd),
		.sts         (sts),
		.req         (in_data),
		.grid_width  (grid_width_q),
		.grid_height (grid_height_q),
		.out_valid   (out_valid),
		.out_stall   (out_stall),
		.out_data    (out_data)
	);

endmodule

// ===== rtl/flr_ctrl.sv =====
// ----------------------------------------------------------------------------
// flr_ctrl: line rasterizer controller
// Two-state machine: waits for a request, then steps the datapath one
// cell per cycle whenever the output register can take it.
// ----------------------------------------------------------------------------
module flr_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  flr_pkg::dp_status_t sts,
	output flr_pkg::dp_cmd_t    cmd
);

	flr_pkg::state_t state_q;
	flr_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= flr_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			flr_pkg::ST_IDLE: begin
				if (in_valid) state_d = flr_pkg::ST_RUN;
			end
			flr_pkg::ST_RUN: begin
				if (sts.out_free && sts.last) state_d = flr_pkg::ST_IDLE;
			end
			default: state_d = flr_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd.load = 1'b0;
		cmd.step = 1'b0;
		in_stall = 1'b1;
		case (state_q)
			flr_pkg::ST_IDLE: begin
				in_stall = 1'b0;
				cmd.load = in_valid;
			end
			flr_pkg::ST_RUN: begin
				cmd.step = sts.out_free;
			end
			default: begin
				in_stall = 1'b1;
			end
		endcase
	end

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && sts.last) |=> (state_q == flr_pkg::ST_IDLE))
		else $error("controller stayed busy after the final cell");

	a_load_starts_run: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> (state_q == flr_pkg::ST_RUN))
		else $error("accepted request did not start a line");

	a_no_step_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |-> !cmd.step)
		else $error("cell stepped in the request transfer cycle");

endmodule

// ===== rtl/flr_dpath.sv =====
// ----------------------------------------------------------------------------
// flr_dpath: line rasterizer datapath
// Setup of axis distances and error term, the Bresenham stepper, cell
// formatting against the grid size, and the output register.
// ----------------------------------------------------------------------------
module flr_dpath (
	input  logic                         clk,
	input  logic                         arst_n,
	input  flr_pkg::dp_cmd_t             cmd,
	output flr_pkg::dp_status_t          sts,
	input  flr_pkg::line_req_t           req,
	input  logic [flr_pkg::COORD_W-1:0]  grid_width,
	input  logic [flr_pkg::COORD_W-1:0]  grid_height,
	output logic                         out_valid,
	input  logic                         out_stall,
	output flr_pkg::cell_t               out_data
);

	localparam int CW = flr_pkg::COORD_W;
	localparam int TW = flr_pkg::TWICE_W;
	localparam int EW = flr_pkg::ERR_W;

	logic [CW-1:0]                cur_x_q, cur_y_q, end_x_q, end_y_q;
	logic signed [EW-1:0]         err_q;
	logic                         step_x_neg_q, step_y_neg_q, steep_swap_q, coinc_q;
	logic [TW-1:0]                major_twice_q, minor_twice_q;
	logic [flr_pkg::CNT_W-1:0]    cnt_q;
	logic                         out_valid_q;
	flr_pkg::cell_t               out_q;

	// setup terms
	logic          sx_neg, sy_neg, steep;
	logic [CW-1:0] dx, dy, major, minor;

	always_comb begin
		sx_neg = req.end_x < req.start_x;
		sy_neg = req.end_y < req.start_y;
		dx     = sx_neg ? req.start_x - req.end_x : req.end_x - req.start_x;
		dy     = sy_neg ? req.start_y - req.end_y : req.end_y - req.start_y;
		steep  = dy > dx;
		major  = steep ? dy : dx;
		minor  = steep ? dx : dy;
	end

	// stepping terms
	logic          at_end, last, err_pos, in_grid;
	logic [CW-1:0] x_next_step, y_next_step, row;
	flr_pkg::cell_t cell_d;

	always_comb begin
		at_end      = (cur_x_q == end_x_q) && (cur_y_q == end_y_q);
		last        = at_end || (cnt_q == flr_pkg::CNT_W'(flr_pkg::MAX_STEPS));
		err_pos     = !err_q[EW-1] && (err_q != '0);
		x_next_step = step_x_neg_q ? cur_x_q - CW'(1) : cur_x_q + CW'(1);
		y_next_step = step_y_neg_q ? cur_y_q - CW'(1) : cur_y_q + CW'(1);
		in_grid     = (cur_x_q <= grid_width) && (cur_y_q <= grid_height);
		row         = grid_height - cur_y_q + CW'(1);
		cell_d.cell_column = cur_x_q;
		cell_d.last_cell   = last;
		if (coinc_q) begin
			cell_d.cell_row = '0;
			cell_d.drawn    = 1'b0;
		end else begin
			cell_d.cell_row = in_grid ? row : '0;
			cell_d.drawn    = in_grid;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			cur_x_q       <= req.start_x;
			cur_y_q       <= req.start_y;
			end_x_q       <= req.end_x;
			end_y_q       <= req.end_y;
			step_x_neg_q  <= sx_neg;
			step_y_neg_q  <= sy_neg;
			steep_swap_q  <= steep;
			coinc_q       <= (req.start_x == req.end_x) && (req.start_y == req.end_y);
			major_twice_q <= {1'b0, major, 1'b0};
			minor_twice_q <= {1'b0, minor, 1'b0};
			err_q         <= $signed({2'b00, minor, 1'b0}) - $signed({3'b000, major});
		end else if (cmd.step) begin
			if (err_pos) begin
				if (steep_swap_q) cur_x_q <= x_next_step;
				else              cur_y_q <= y_next_step;
				err_q <= err_q - $signed({1'b0, major_twice_q});
			end else begin
				if (steep_swap_q) cur_y_q <= y_next_step;
				else              cur_x_q <= x_next_step;
				err_q <= err_q + $signed({1'b0, minor_twice_q});
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (cmd.load) begin
			cnt_q <= '0;
		end else if (cmd.step && !last) begin
			cnt_q <= cnt_q + flr_pkg::CNT_W'(1);
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.step) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.step) out_q <= cell_d;
	end

	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.last     = last;
	assign out_valid    = out_valid_q;
	assign out_data     = out_q;

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= flr_pkg::CNT_W'(flr_pkg::MAX_STEPS))
		else $error("cell count ran past the step bound");

	a_coinc_single: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.step && coinc_q) |-> last)
		else $error("coincident endpoints did not end on first cell");

	a_last_flag: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.step |=> (out_valid_q && (out_q.last_cell == $past(last))))
		else $error("output register lost the final-cell flag");

endmodule
